// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the pose integrator.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define UPI_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UPI_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define UPI_ASSERT(lbl, clk, rst_n, prop, msg)
`define UPI_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// File: rtl/upi_pkg.sv
// Types, widths, constants and the arctangent table of the pose integrator.
// Depends on nothing; imported by the interfaces and modules of the RTL.
package upi_pkg;

	// Payload types.
	typedef logic signed [15:0] speed_t;
	typedef logic signed [20:0] rate_t;
	typedef logic signed [31:0] pos_t;
	typedef logic signed [15:0] head_t;
	typedef logic [15:0]        dt_t;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_X       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_Y       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_START_HEADING = 3'd3;
	localparam dt_t TIME_STEP_RESET = 16'd655;

	// Rotation engine.
	localparam int CORDIC_STEPS = 16;
	localparam int ANGLE_BITS   = 16;
	localparam int CNT_W        = $clog2(CORDIC_STEPS);
	localparam int Z_W          = ANGLE_BITS + 2;
	localparam int XY_W         = 34;
	localparam int ATAN_DROP    = 32 - ANGLE_BITS;
	localparam int HEAD_SHL     = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
	localparam int HEAD_SHR     = (ANGLE_BITS >= 16) ? 0 : 16 - ANGLE_BITS;
	localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);
	localparam logic signed [Z_W-1:0]  QUARTER_TURN = Z_W'(1 << (ANGLE_BITS - 2));
	localparam logic signed [Z_W-1:0]  HALF_TURN    = Z_W'(1 << (ANGLE_BITS - 1));

	// Shared multiplier and accumulator.
	localparam int MA_W  = 17;
	localparam int MB_W  = XY_W;
	localparam int MP_W  = MA_W + MB_W;
	localparam int ACC_W = 68;
	localparam int SUM_W = 34;

	// atan(2^-i) with 2^32 units per turn.
	localparam logic [31:0] ATAN_TAB32 [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
		32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
		32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
		32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	// Arctangent entry rounded half up to the angle resolution.
	function automatic logic signed [Z_W-1:0] atan_at(input logic [4:0] idx);
		logic [32:0] t;
		t = '0;
		if (idx < 5'd24) begin
			t = {1'b0, ATAN_TAB32[idx]} + (33'd1 << (ATAN_DROP - 1));
		end
		return Z_W'(t >> ATAN_DROP);
	endfunction

	// Rotation engine result, held stable until the next start.
	typedef struct packed {
		logic                   done;
		logic signed [XY_W-1:0] cos_v;
		logic signed [XY_W-1:0] sin_v;
	} cord_rsp_t;

endpackage

// File: rtl/upi_cmd_if.sv
// Command channel of the pose integrator: one tick or one reload per beat.
// Depends on upi_pkg.
interface upi_cmd_if;
	import upi_pkg::*;

	logic   valid;
	logic   ready;
	logic   action;
	speed_t linear_speed;
	rate_t  turn_rate;

	modport source (output valid, action, linear_speed, turn_rate, input ready);
	modport sink (input valid, action, linear_speed, turn_rate, output ready);
endinterface

// File: rtl/upi_rsp_if.sv
// Result channel of the pose integrator: absolute pose and odometry per beat.
// Depends on upi_pkg.
interface upi_rsp_if;
	import upi_pkg::*;

	logic  valid;
	logic  ready;
	pos_t  abs_x;
	pos_t  abs_y;
	head_t abs_heading;
	pos_t  odom_x;
	pos_t  odom_y;
	head_t odom_heading;
	logic  saturated;

	modport source (output valid, abs_x, abs_y, abs_heading, odom_x, odom_y,
		odom_heading, saturated, input ready);
	modport sink (input valid, abs_x, abs_y, abs_heading, odom_x, odom_y,
		odom_heading, saturated, output ready);
endinterface

// File: rtl/unicycle_pose_integrator_core.sv
// Integrate tick: from the accepting edge to the result beat come 16 CORDIC
// micro-rotations, a wait to see the engine finish, 8 multiplier steps, one load.
// A new command is taken once the result is registered; a reload skips
// the rotation and multiplier steps. The result register lets the next
// command in while a result still waits. Reset (arst_n low, asynchronous)
// zeroes the pose and start registers and sets the time step to 655.
`include "assert_macros.svh"

module unicycle_pose_integrator_core (
	input  logic                             clk,
	input  logic                             arst_n,
	upi_cmd_if.sink                          cmd,
	upi_rsp_if.source                        rsp,
	input  logic                             wr_en,
	input  logic [upi_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [upi_pkg::CFG_DATA_W-1:0]   wr_data
);
	import upi_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CORD = 4'd1;
	localparam logic [3:0] S_K0   = 4'd2;
	localparam logic [3:0] S_K1   = 4'd3;
	localparam logic [3:0] S_K2   = 4'd4;
	localparam logic [3:0] S_K3   = 4'd5;
	localparam logic [3:0] S_K4   = 4'd6;
	localparam logic [3:0] S_K5   = 4'd7;
	localparam logic [3:0] S_K6   = 4'd8;
	localparam logic [3:0] S_K7   = 4'd9;
	localparam logic [3:0] S_ODOM = 4'd10;

	localparam logic signed [SUM_W-1:0] POS_MAX = SUM_W'(64'sd2147483647);
	localparam logic signed [SUM_W-1:0] POS_MIN = SUM_W'(-64'sd2147483648);

	function automatic logic [32:0] sat_pos(input logic signed [SUM_W-1:0] v);
		logic [32:0] r;
		r = {1'b0, v[31:0]};
		if (v > POS_MAX) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < POS_MIN) begin
			r = {1'b1, 32'h8000_0000};
		end
		return r;
	endfunction

	logic [3:0]              state_q;
	dt_t                     time_step_q;
	pos_t                    start_x_q;
	pos_t                    start_y_q;
	head_t                   start_head_q;
	pos_t                    pose_x_q;
	pos_t                    pose_y_q;
	head_t                   pose_head_q;
	speed_t                  speed_q;
	rate_t                   rate_q;
	logic                    reload_q;
	logic                    clip_q;
	logic signed [32:0]      vdt_q;
	head_t                   head_next_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    rsp_valid_q;
	pos_t                    out_abs_x_q;
	pos_t                    out_abs_y_q;
	head_t                   out_abs_head_q;
	pos_t                    out_odom_x_q;
	pos_t                    out_odom_y_q;
	head_t                   out_odom_head_q;
	logic                    out_sat_q;

	logic                    cmd_fire;
	logic                    cord_start;
	cord_rsp_t               cord_rsp;
	logic signed [MA_W-1:0]  mul_a;
	logic signed [MB_W-1:0]  mul_b;
	logic signed [MP_W-1:0]  prod;
	logic signed [MA_W-1:0]  vdt_hi;
	logic signed [MA_W-1:0]  vdt_lo;
	logic signed [SUM_W-1:0] pos_sum;
	logic [32:0]             pos_sat;
	logic signed [SUM_W-1:0] odx_dif;
	logic signed [SUM_W-1:0] ody_dif;
	logic [32:0]             odx_sat;
	logic [32:0]             ody_sat;
	logic                    out_load;

	assign cmd.ready  = (state_q == S_IDLE);
	assign cmd_fire   = cmd.valid && cmd.ready;
	assign cord_start = cmd_fire && !cmd.action;

	upi_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cord_start),
		.heading (pose_head_q),
		.rsp     (cord_rsp)
	);

	// v*dt is split at bit 16 so that each partial product fits the multiplier.
	assign vdt_hi = vdt_q[32:16];
	assign vdt_lo = signed'({1'b0, vdt_q[15:0]});

	always_comb begin
		case (state_q)
			S_K1: begin
				mul_a = signed'({1'b0, time_step_q});
				mul_b = MB_W'(rate_q);
			end
			S_K2: begin
				mul_a = vdt_hi;
				mul_b = cord_rsp.cos_v;
			end
			S_K3: begin
				mul_a = vdt_lo;
				mul_b = cord_rsp.cos_v;
			end
			S_K4: begin
				mul_a = vdt_hi;
				mul_b = cord_rsp.sin_v;
			end
			S_K5: begin
				mul_a = vdt_lo;
				mul_b = cord_rsp.sin_v;
			end
			default: begin
				mul_a = signed'({1'b0, time_step_q});
				mul_b = MB_W'(speed_q);
			end
		endcase
	end

	upi_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	// Rounding half up by 2^38 becomes a carry-in of bit 37 on the pose add.
	always_comb begin
		pos_sum = (state_q == S_K5) ? SUM_W'(pose_x_q) : SUM_W'(pose_y_q);
		pos_sum = pos_sum + SUM_W'(signed'(acc_q[ACC_W-1:38])) +
			signed'({33'd0, acc_q[37]});
		pos_sat = sat_pos(pos_sum);
	end

	assign odx_dif  = SUM_W'(pose_x_q) - SUM_W'(start_x_q);
	assign ody_dif  = SUM_W'(pose_y_q) - SUM_W'(start_y_q);
	assign odx_sat  = sat_pos(odx_dif);
	assign ody_sat  = sat_pos(ody_dif);
	assign out_load = (state_q == S_ODOM) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			time_step_q  <= TIME_STEP_RESET;
			start_x_q    <= '0;
			start_y_q    <= '0;
			start_head_q <= '0;
			pose_x_q     <= '0;
			pose_y_q     <= '0;
			pose_head_q  <= '0;
			speed_q      <= '0;
			rate_q       <= '0;
			reload_q     <= 1'b0;
			clip_q       <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					REG_TIME_STEP:     time_step_q  <= wr_data[15:0];
					REG_START_X:       start_x_q    <= wr_data;
					REG_START_Y:       start_y_q    <= wr_data;
					REG_START_HEADING: start_head_q <= wr_data[15:0];
					default: ;
				endcase
			end
			if (rsp_valid_q && rsp.ready && !out_load) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						clip_q   <= 1'b0;
						reload_q <= cmd.action;
						speed_q  <= cmd.linear_speed;
						rate_q   <= cmd.turn_rate;
						if (cmd.action) begin
							pose_x_q    <= start_x_q;
							pose_y_q    <= start_y_q;
							pose_head_q <= start_head_q;
							state_q     <= S_ODOM;
						end else begin
							state_q <= S_CORD;
						end
					end
				end
				S_CORD: begin
					if (cord_rsp.done) begin
						state_q <= S_K0;
					end
				end
				S_K0: state_q <= S_K1;
				S_K1: state_q <= S_K2;
				S_K2: state_q <= S_K3;
				S_K3: state_q <= S_K4;
				S_K4: state_q <= S_K5;
				S_K5: begin
					pose_x_q <= pos_sat[31:0];
					clip_q   <= clip_q | pos_sat[32];
					state_q  <= S_K6;
				end
				S_K6: state_q <= S_K7;
				S_K7: begin
					pose_y_q    <= pos_sat[31:0];
					pose_head_q <= head_next_q;
					clip_q      <= clip_q | pos_sat[32];
					state_q     <= S_ODOM;
				end
				S_ODOM: begin
					if (out_load) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Multiply-accumulate datapath; each product is registered and consumed in the next state.
	always_ff @(posedge clk) begin
		case (state_q)
			S_K1: vdt_q <= prod[32:0];
			S_K2: head_next_q <= pose_head_q + prod[31:16] + {15'd0, prod[15]};
			S_K3: acc_q <= ACC_W'(prod) <<< 16;
			S_K4: acc_q <= acc_q + ACC_W'(prod);
			S_K5: acc_q <= ACC_W'(prod) <<< 16;
			S_K6: acc_q <= acc_q + ACC_W'(prod);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_abs_x_q     <= pose_x_q;
			out_abs_y_q     <= pose_y_q;
			out_abs_head_q  <= pose_head_q;
			out_odom_x_q    <= odx_sat[31:0];
			out_odom_y_q    <= ody_sat[31:0];
			out_odom_head_q <= pose_head_q - start_head_q;
			out_sat_q       <= clip_q | odx_sat[32] | ody_sat[32];
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.abs_x        = out_abs_x_q;
	assign rsp.abs_y        = out_abs_y_q;
	assign rsp.abs_heading  = out_abs_head_q;
	assign rsp.odom_x       = out_odom_x_q;
	assign rsp.odom_y       = out_odom_y_q;
	assign rsp.odom_heading = out_odom_head_q;
	assign rsp.saturated    = out_sat_q;

	`UPI_ASSERT(a_busy_after_accept, clk, arst_n, cmd_fire |=> !cmd.ready, "ready after accept")
	`UPI_NEVER(a_done_in_wait, clk, arst_n, cord_rsp.done && (state_q != S_CORD), "stray done")
	`UPI_ASSERT(a_reload_pose, clk, arst_n, (state_q == S_ODOM && reload_q) |-> (pose_x_q == start_x_q && pose_y_q == start_y_q), "reload pose mismatch")

endmodule

// File: rtl/upi_cordic.sv
// Iterative rotation-mode CORDIC: one micro-rotation per cycle on one shared
// add/shift unit. Depends on upi_pkg.
module upi_cordic (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  upi_pkg::head_t    heading,
	output upi_pkg::cord_rsp_t rsp
);
	import upi_pkg::*;

	logic                   busy_q;
	logic                   done_q;
	logic [CNT_W-1:0]       cnt_q;
	logic signed [XY_W-1:0] x_q;
	logic signed [XY_W-1:0] y_q;
	logic signed [Z_W-1:0]  z_q;
	logic                   neg_q;

	logic signed [41:0]     head_wide;
	logic signed [Z_W-1:0]  z_init;
	logic signed [Z_W-1:0]  z_fold;
	logic                   neg_fold;
	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	logic signed [Z_W-1:0]  ang;
	logic                   last_iter;

	// Bring the heading to the engine's angle resolution, then fold it into
	// the right half plane; the result is negated at the end instead.
	always_comb begin
		head_wide = 42'(heading);
		head_wide = (head_wide <<< HEAD_SHL) >>> HEAD_SHR;
		z_init    = Z_W'(head_wide);
		z_fold    = z_init;
		neg_fold  = 1'b0;
		if (z_init > QUARTER_TURN) begin
			z_fold   = z_init - HALF_TURN;
			neg_fold = 1'b1;
		end else if (z_init < -QUARTER_TURN) begin
			z_fold   = z_init + HALF_TURN;
			neg_fold = 1'b1;
		end
	end

	assign xs        = x_q >>> cnt_q;
	assign ys        = y_q >>> cnt_q;
	assign ang       = atan_at(5'(cnt_q));
	assign last_iter = (cnt_q == CNT_W'(CORDIC_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && last_iter;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_iter) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= CORDIC_GAIN;
			y_q   <= '0;
			z_q   <= z_fold;
			neg_q <= neg_fold;
		end else if (busy_q) begin
			if (!z_q[Z_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ang;
			end
		end
	end

	assign rsp.done  = done_q;
	assign rsp.cos_v = neg_q ? -x_q : x_q;
	assign rsp.sin_v = neg_q ? -y_q : y_q;

endmodule

// File: rtl/upi_mul.sv
// Shared signed multiplier with a registered product.
// Depends on upi_pkg.
module upi_mul (
	input  logic                            clk,
	input  logic signed [upi_pkg::MA_W-1:0] a,
	input  logic signed [upi_pkg::MB_W-1:0] b,
	output logic signed [upi_pkg::MP_W-1:0] prod_q
);
	import upi_pkg::*;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule
